/* rtl/core/chunk_hash_table_lookup_macros.svh */
// Assertion macros for the checker file.
// Needs nothing else; take it in with a plain include.
`ifndef CHUNK_HASH_TABLE_LOOKUP_MACROS_SVH
`define CHUNK_HASH_TABLE_LOOKUP_MACROS_SVH

// Clocked check, switched off while reset is held.
`define CHT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("chunk_hash_table_lookup: assertion failed");

// Clocked check that also holds through reset.
`define CHT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("chunk_hash_table_lookup: assertion failed");

`endif

/* rtl/core/cht_pkg.sv */
// Shared constants, request codes and word types of the region table.
// Used by every module of the block; depends on nothing.
package cht_pkg;

    localparam int TABLE_DEPTH  = 64;
    localparam int IDX_W        = $clog2(TABLE_DEPTH);
    localparam int CNT_W        = IDX_W + 1;
    localparam int REGION_SHIFT = 6;
    localparam int COORD_W      = 32;
    localparam int REGION_W     = COORD_W - REGION_SHIFT;
    localparam int FIELD_W      = 10;
    localparam int KEY_W        = 31;
    localparam int HANDLE_W     = 16;
    localparam int ENTRY_W      = KEY_W + HANDLE_W;
    localparam int SLOT_W       = 6;
    localparam int POS_W        = 6;
    localparam int REQ_W        = 2;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = QPTR_W + 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_WRITE  = 2'd1,
        REQ_SORT   = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef struct packed {
        t_req                req;
        logic [REGION_W-1:0] rx;
        logic [REGION_W-1:0] ry;
        logic [REGION_W-1:0] rz;
        logic [KEY_W-1:0]    key;
        logic                slot_ok;
        logic [IDX_W-1:0]    slot;
        logic [KEY_W-1:0]    slot_key;
        logic [HANDLE_W-1:0] slot_handle;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic                found;
        logic [POS_W-1:0]    position;
        logic [HANDLE_W-1:0] handle;
        logic [KEY_W-1:0]    key;
        logic                done_res;
    } t_res;

endpackage

/* rtl/core/cht_front.sv */
// Front end: takes request words, derives region coordinates and key.
// Depends on cht_pkg.
module cht_front (
    input  logic                              start,
    input  cht_pkg::t_q_stat                  i_stat,
    input  logic [cht_pkg::REQ_W-1:0]         i_req_type,
    input  logic signed [cht_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [cht_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [cht_pkg::COORD_W-1:0] i_coord_z,
    input  logic [cht_pkg::SLOT_W-1:0]        i_slot_index,
    input  logic [cht_pkg::KEY_W-1:0]         i_slot_key,
    input  logic [cht_pkg::HANDLE_W-1:0]      i_slot_handle,
    output logic                              busy,
    output logic                              o_push,
    output cht_pkg::t_cmd                     o_cmd
);

    logic signed [cht_pkg::COORD_W-1:0] sx, sy, sz;
    logic [3*cht_pkg::FIELD_W-1:0]      packed_key;

    assign sx = i_coord_x >>> cht_pkg::REGION_SHIFT;
    assign sy = i_coord_y >>> cht_pkg::REGION_SHIFT;
    assign sz = i_coord_z >>> cht_pkg::REGION_SHIFT;

    assign packed_key = {sz[cht_pkg::FIELD_W-1:0], sy[cht_pkg::FIELD_W-1:0],
                         sx[cht_pkg::FIELD_W-1:0]};

    assign busy   = i_stat.full;
    assign o_push = start && !i_stat.full;

    always_comb begin
        o_cmd.req         = cht_pkg::t_req'(i_req_type);
        o_cmd.rx          = sx[cht_pkg::REGION_W-1:0];
        o_cmd.ry          = sy[cht_pkg::REGION_W-1:0];
        o_cmd.rz          = sz[cht_pkg::REGION_W-1:0];
        o_cmd.key         = cht_pkg::KEY_W'(packed_key) + cht_pkg::KEY_W'(1);
        o_cmd.slot_ok     = (32'(i_slot_index) < 32'(cht_pkg::TABLE_DEPTH));
        o_cmd.slot        = cht_pkg::IDX_W'(i_slot_index);
        o_cmd.slot_key    = i_slot_key;
        o_cmd.slot_handle = i_slot_handle;
    end

endmodule

/* rtl/core/cht_queue.sv */
// Short command queue between the front end and the back end.
// Depends on cht_pkg.
module cht_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cht_pkg::t_cmd    i_cmd,
    input  logic             i_pop,
    output cht_pkg::t_cmd    o_cmd,
    output cht_pkg::t_q_stat o_stat
);

    cht_pkg::t_cmd               r_mem [cht_pkg::QUEUE_DEPTH];
    logic [cht_pkg::QPTR_W-1:0]  r_wr, r_rd, n_wr, n_rd;
    logic [cht_pkg::QCNT_W-1:0]  r_cnt, n_cnt;

    always_comb begin
        n_wr  = i_push ? r_wr + cht_pkg::QPTR_W'(1) : r_wr;
        n_rd  = i_pop  ? r_rd + cht_pkg::QPTR_W'(1) : r_rd;
        n_cnt = r_cnt + cht_pkg::QCNT_W'(i_push) - cht_pkg::QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    assign o_cmd        = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == cht_pkg::QCNT_W'(cht_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

/* rtl/core/cht_back.sv */
// Back end: table memory, binary search, bubble sort and result cache.
// Depends on cht_pkg.
module cht_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  cht_pkg::t_cmd    i_cmd,
    input  cht_pkg::t_q_stat i_stat,
    output logic             o_pop,
    output logic             o_res_valid,
    output cht_pkg::t_res    o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_SORT_CARRY,
        S_SORT_STEP,
        S_SORT_END
    } t_state;

    localparam int KW = cht_pkg::KEY_W;
    localparam int HW = cht_pkg::HANDLE_W;
    localparam int EW = cht_pkg::ENTRY_W;
    localparam int IW = cht_pkg::IDX_W;
    localparam int CW = cht_pkg::CNT_W;
    localparam int RW = cht_pkg::REGION_W;

    // table memory, one key/handle word per slot
    logic [EW-1:0]                  mem [cht_pkg::TABLE_DEPTH];
    logic [cht_pkg::TABLE_DEPTH-1:0] r_vld;
    logic [EW-1:0]                  r_rd_data;
    logic                           r_rd_vld;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_first, n_first, r_lp1, n_lp1;
    logic [IW-1:0]   r_mid, n_mid;
    logic [KW-1:0]   r_key, n_key;
    logic            r_cache_vld, n_cache_vld;
    logic [RW-1:0]   r_last_x, n_last_x, r_last_y, n_last_y, r_last_z, n_last_z;
    cht_pkg::t_res   r_cache, n_cache;
    logic [IW-1:0]   r_pass, n_pass, r_j, n_j;
    logic [EW-1:0]   r_carry, n_carry;
    logic            r_res_valid, n_res_valid;
    cht_pkg::t_res   r_res, n_res;

    logic            we;
    logic [IW-1:0]   waddr, raddr, lim;
    logic [EW-1:0]   wdata, rd_entry;
    logic [KW-1:0]   rd_key;
    logic [HW-1:0]   rd_handle;
    logic            hit;
    logic [CW-1:0]   nf, nl;
    logic [CW:0]     msum;

    assign rd_entry  = r_rd_vld ? r_rd_data : '0;
    assign rd_key    = rd_entry[EW-1:HW];
    assign rd_handle = rd_entry[HW-1:0];
    assign lim       = IW'(cht_pkg::TABLE_DEPTH - 1) - r_pass;
    assign hit       = r_cache_vld && (i_cmd.rx == r_last_x) && (i_cmd.ry == r_last_y)
                       && (i_cmd.rz == r_last_z);

    always_comb begin
        n_state     = r_state;
        n_first     = r_first;
        n_lp1       = r_lp1;
        n_mid       = r_mid;
        n_key       = r_key;
        n_cache_vld = r_cache_vld;
        n_last_x    = r_last_x;
        n_last_y    = r_last_y;
        n_last_z    = r_last_z;
        n_cache     = r_cache;
        n_pass      = r_pass;
        n_j         = r_j;
        n_carry     = r_carry;
        n_res_valid = 1'b0;
        n_res       = r_res;
        o_pop       = 1'b0;
        we          = 1'b0;
        waddr       = r_j;
        wdata       = r_carry;
        raddr       = r_mid;
        nf          = r_first;
        nl          = r_lp1;
        msum        = '0;

        unique case (r_state)
            S_IDLE: begin
                if (!i_stat.empty) begin
                    o_pop = 1'b1;
                    n_res = '0;
                    unique case (i_cmd.req)
                        cht_pkg::REQ_LOOKUP: begin
                            n_key = i_cmd.key;
                            if (hit) begin
                                n_res_valid    = 1'b1;
                                n_res          = r_cache;
                                n_res.key      = i_cmd.key;
                                n_res.done_res = 1'b1;
                            end else begin
                                n_last_x = i_cmd.rx;
                                n_last_y = i_cmd.ry;
                                n_last_z = i_cmd.rz;
                                n_first  = '0;
                                n_lp1    = CW'(cht_pkg::TABLE_DEPTH);
                                n_mid    = IW'((cht_pkg::TABLE_DEPTH - 1) / 2);
                                raddr    = n_mid;
                                n_state  = S_SRCH;
                            end
                        end
                        cht_pkg::REQ_WRITE: begin
                            we             = i_cmd.slot_ok;
                            waddr          = i_cmd.slot;
                            wdata          = {i_cmd.slot_key, i_cmd.slot_handle};
                            n_cache_vld    = 1'b0;
                            n_res_valid    = 1'b1;
                            n_res.done_res = 1'b1;
                        end
                        cht_pkg::REQ_SORT: begin
                            n_cache_vld = 1'b0;
                            n_pass      = '0;
                            raddr       = '0;
                            n_state     = S_SORT_CARRY;
                        end
                        default: begin
                            n_res_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_SRCH: begin
                if (rd_key == r_key) begin
                    n_cache.found    = 1'b1;
                    n_cache.position = cht_pkg::POS_W'(r_mid);
                    n_cache.handle   = rd_handle;
                    n_cache.key      = '0;
                    n_cache.done_res = 1'b0;
                    n_cache_vld      = 1'b1;
                    n_res_valid      = 1'b1;
                    n_res            = n_cache;
                    n_res.key        = r_key;
                    n_res.done_res   = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    // narrow towards smaller keys when the slot key is larger
                    nf      = (rd_key > r_key) ? CW'(r_mid) + CW'(1) : r_first;
                    nl      = (rd_key > r_key) ? r_lp1 : CW'(r_mid);
                    n_first = nf;
                    n_lp1   = nl;
                    if (nf < nl) begin
                        msum  = (CW+1)'(nf) + (CW+1)'(nl) - (CW+1)'(1);
                        n_mid = msum[IW:1];
                        raddr = n_mid;
                    end else begin
                        n_cache        = '0;
                        n_cache_vld    = 1'b1;
                        n_res_valid    = 1'b1;
                        n_res          = '0;
                        n_res.key      = r_key;
                        n_res.done_res = 1'b1;
                        n_state        = S_IDLE;
                    end
                end
            end
            S_SORT_CARRY: begin
                n_carry = rd_entry;
                n_j     = '0;
                raddr   = IW'(1);
                n_state = S_SORT_STEP;
            end
            S_SORT_STEP: begin
                // keep the smaller key travelling, drop the larger one into place
                we    = 1'b1;
                waddr = r_j;
                if (r_carry[EW-1:HW] < rd_key) begin
                    wdata = rd_entry;
                end else begin
                    wdata   = r_carry;
                    n_carry = rd_entry;
                end
                if (r_j + IW'(1) == lim) begin
                    n_state = S_SORT_END;
                end else begin
                    n_j   = r_j + IW'(1);
                    raddr = r_j + IW'(2);
                end
            end
            S_SORT_END: begin
                we    = 1'b1;
                waddr = lim;
                wdata = r_carry;
                if (r_pass == IW'(cht_pkg::TABLE_DEPTH - 2)) begin
                    n_res_valid    = 1'b1;
                    n_res          = '0;
                    n_res.done_res = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_pass  = r_pass + IW'(1);
                    raddr   = '0;
                    n_state = S_SORT_CARRY;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cache_vld <= 1'b0;
            r_res_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            r_state     <= n_state;
            r_cache_vld <= n_cache_vld;
            r_res_valid <= n_res_valid;
            if (we) begin
                r_vld[waddr] <= 1'b1;
            end
        end
        r_first  <= n_first;
        r_lp1    <= n_lp1;
        r_mid    <= n_mid;
        r_key    <= n_key;
        r_last_x <= n_last_x;
        r_last_y <= n_last_y;
        r_last_z <= n_last_z;
        r_cache  <= n_cache;
        r_pass   <= n_pass;
        r_j      <= n_j;
        r_carry  <= n_carry;
        r_res    <= n_res;
        r_rd_vld <= r_vld[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd_data <= mem[raddr];
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

/* rtl/core/chunk_hash_table_lookup.sv */
// Top level of the sorted region table: front end, command queue, back end.
// Depends on cht_pkg, cht_front, cht_queue and cht_back.
//
//   channel   handshake                 payload
//   request   start in, busy out        i_req_type .. i_slot_handle
//   result    o_result_valid strobe     o_found .. o_done_res
//
// A request enters the two-word queue in the cycle start is seen with busy low.
// The back end takes one word at a time: a cache hit, write or unused code
// gives its result in the cycle after it leaves the queue; a lookup miss runs
// a binary search with one table read per step before its result appears.
// A sort runs one memory read and write per cycle.
// Reset is synchronous and clears the table to empty; results cannot be stalled.
module chunk_hash_table_lookup (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [cht_pkg::REQ_W-1:0]          i_req_type,
    input  logic signed [cht_pkg::COORD_W-1:0] i_coord_x,
    input  logic signed [cht_pkg::COORD_W-1:0] i_coord_y,
    input  logic signed [cht_pkg::COORD_W-1:0] i_coord_z,
    input  logic [cht_pkg::SLOT_W-1:0]         i_slot_index,
    input  logic [cht_pkg::KEY_W-1:0]          i_slot_key,
    input  logic [cht_pkg::HANDLE_W-1:0]       i_slot_handle,
    output logic                               o_result_valid,
    output logic                               o_found,
    output logic [cht_pkg::POS_W-1:0]          o_position,
    output logic [cht_pkg::HANDLE_W-1:0]       o_handle,
    output logic [cht_pkg::KEY_W-1:0]          o_key,
    output logic                               o_done_res
);

    cht_pkg::t_cmd    front_cmd, queue_cmd;
    cht_pkg::t_q_stat q_stat;
    cht_pkg::t_res    res;
    logic             push, pop;

    cht_front u_front (
        .start         (start),
        .i_stat        (q_stat),
        .i_req_type    (i_req_type),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .i_coord_z     (i_coord_z),
        .i_slot_index  (i_slot_index),
        .i_slot_key    (i_slot_key),
        .i_slot_handle (i_slot_handle),
        .busy          (busy),
        .o_push        (push),
        .o_cmd         (front_cmd)
    );

    cht_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_stat  (q_stat)
    );

    cht_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_stat      (q_stat),
        .o_pop       (pop),
        .o_res_valid (o_result_valid),
        .o_res       (res)
    );

    assign o_found    = res.found;
    assign o_position = res.position;
    assign o_handle   = res.handle;
    assign o_key      = res.key;
    assign o_done_res = res.done_res;

endmodule

/* rtl/core/cht_checker.sv */
// Port-level checks on the region table, bound to the top level.
// Depends on cht_pkg and chunk_hash_table_lookup_macros.svh.
`include "chunk_hash_table_lookup_macros.svh"

module cht_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic [cht_pkg::REQ_W-1:0]          i_req_type,
    input logic signed [cht_pkg::COORD_W-1:0] i_coord_x,
    input logic signed [cht_pkg::COORD_W-1:0] i_coord_y,
    input logic signed [cht_pkg::COORD_W-1:0] i_coord_z,
    input logic [cht_pkg::SLOT_W-1:0]         i_slot_index,
    input logic [cht_pkg::KEY_W-1:0]          i_slot_key,
    input logic [cht_pkg::HANDLE_W-1:0]       i_slot_handle,
    input logic                               o_result_valid,
    input logic                               o_found,
    input logic [cht_pkg::POS_W-1:0]          o_position,
    input logic [cht_pkg::HANDLE_W-1:0]       o_handle,
    input logic [cht_pkg::KEY_W-1:0]          o_key,
    input logic                               o_done_res
);

    // no result and busy low straight after reset
    `CHT_ASSERT_ALWAYS(a_no_res_after_rst, i_clk, !i_rst_n |=> !o_result_valid && !busy)
    // a hit is always a completed lookup with a non-zero key
    `CHT_ASSERT(a_found_done, i_clk, i_rst_n,
        o_result_valid && o_found |-> o_done_res && (o_key != '0))
    // a miss reports neither slot nor handle
    `CHT_ASSERT(a_miss_clear, i_clk, i_rst_n,
        o_result_valid && !o_found |-> (o_position == '0) && (o_handle == '0))
    // a result with done_res low (an unused request code) has found and key clear
    `CHT_ASSERT(a_none_clear, i_clk, i_rst_n,
        o_result_valid && !o_done_res |-> !o_found && (o_key == '0))

endmodule

bind chunk_hash_table_lookup cht_checker u_cht_checker (.*);

/* bench/chunk_hash_table_lookup_test.sv */
// Self-checking bench for the sorted region table: writes, sorts and lookups
// are predicted in the bench and each result word is compared as it strobes.
// Depends on cht_pkg and the chunk_hash_table_lookup top level.
`timescale 1ns / 1ps

module chunk_hash_table_lookup_test;

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 start = 1'b0;
    logic                                 busy;
    logic [cht_pkg::REQ_W-1:0]            i_req_type = '0;
    logic signed [cht_pkg::COORD_W-1:0]   i_coord_x = '0;
    logic signed [cht_pkg::COORD_W-1:0]   i_coord_y = '0;
    logic signed [cht_pkg::COORD_W-1:0]   i_coord_z = '0;
    logic [cht_pkg::SLOT_W-1:0]           i_slot_index = '0;
    logic [cht_pkg::KEY_W-1:0]            i_slot_key = '0;
    logic [cht_pkg::HANDLE_W-1:0]         i_slot_handle = '0;
    logic                                 o_result_valid;
    logic                                 o_found;
    logic [cht_pkg::POS_W-1:0]            o_position;
    logic [cht_pkg::HANDLE_W-1:0]         o_handle;
    logic [cht_pkg::KEY_W-1:0]            o_key;
    logic                                 o_done_res;

    chunk_hash_table_lookup dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state
    logic [cht_pkg::KEY_W-1:0]    tbl_key [cht_pkg::TABLE_DEPTH];
    logic [cht_pkg::HANDLE_W-1:0] tbl_handle [cht_pkg::TABLE_DEPTH];
    logic [31:0]                  prev_region [3];
    logic                         hit_ok;
    cht_pkg::t_res                hit_res;

    cht_pkg::t_res pending_results[$];
    int            mismatch_count = 0;
    int            send_gap_pct = 0;
    longint        cycle_count = 0;

    function automatic logic [31:0] region_of(logic [31:0] c);
        return $unsigned($signed(c) >>> cht_pkg::REGION_SHIFT);
    endfunction

    function automatic cht_pkg::t_res search_region(logic [cht_pkg::KEY_W-1:0] k);
        cht_pkg::t_res r;
        int lo, hi, mid;
        r = '0;
        lo = 0;
        hi = cht_pkg::TABLE_DEPTH - 1;
        mid = (cht_pkg::TABLE_DEPTH - 1) / 2;
        while (lo <= hi) begin
            if (tbl_key[mid] > k) begin
                lo = mid + 1;
            end else if (tbl_key[mid] == k) begin
                r.found = 1'b1;
                r.position = mid[cht_pkg::POS_W-1:0];
                r.handle = tbl_handle[mid];
                return r;
            end else begin
                hi = mid - 1;
            end
            mid = (lo + hi) / 2;
        end
        return r;
    endfunction

    function automatic cht_pkg::t_res predict_word(cht_pkg::t_req rq, logic [31:0] cx,
                                                   logic [31:0] cy, logic [31:0] cz,
                                                   logic [cht_pkg::SLOT_W-1:0] si,
                                                   logic [cht_pkg::KEY_W-1:0] sk,
                                                   logic [cht_pkg::HANDLE_W-1:0] sh);
        cht_pkg::t_res r;
        logic [31:0] rx, ry, rz, kk;
        logic [cht_pkg::KEY_W-1:0] tk;
        logic [cht_pkg::HANDLE_W-1:0] th;
        r = '0;
        case (rq)
            cht_pkg::REQ_LOOKUP: begin
                rx = region_of(cx);
                ry = region_of(cy);
                rz = region_of(cz);
                kk = {2'b0, rz[9:0], ry[9:0], rx[9:0]} + 32'd1;
                if (!(hit_ok && prev_region[0] == rx && prev_region[1] == ry &&
                      prev_region[2] == rz)) begin
                    prev_region[0] = rx;
                    prev_region[1] = ry;
                    prev_region[2] = rz;
                    hit_res = search_region(kk[cht_pkg::KEY_W-1:0]);
                    hit_ok = 1'b1;
                end
                r = hit_res;
                r.key = kk[cht_pkg::KEY_W-1:0];
                r.done_res = 1'b1;
            end
            cht_pkg::REQ_WRITE: begin
                if (si < cht_pkg::TABLE_DEPTH) begin
                    tbl_key[si] = sk;
                    tbl_handle[si] = sh;
                end
                hit_ok = 1'b0;
                r.done_res = 1'b1;
            end
            cht_pkg::REQ_SORT: begin
                for (int i = 0; i < cht_pkg::TABLE_DEPTH; i++)
                    for (int j = 0; j < cht_pkg::TABLE_DEPTH - 1 - i; j++)
                        if (tbl_key[j] < tbl_key[j+1]) begin
                            tk = tbl_key[j];
                            th = tbl_handle[j];
                            tbl_key[j] = tbl_key[j+1];
                            tbl_handle[j] = tbl_handle[j+1];
                            tbl_key[j+1] = tk;
                            tbl_handle[j+1] = th;
                        end
                hit_ok = 1'b0;
                r.done_res = 1'b1;
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // Send one word; hold start until it is taken
    task automatic send_word(cht_pkg::t_req rq, logic [31:0] cx, logic [31:0] cy,
                             logic [31:0] cz, logic [cht_pkg::SLOT_W-1:0] si,
                             logic [cht_pkg::KEY_W-1:0] sk,
                             logic [cht_pkg::HANDLE_W-1:0] sh);
        while ($urandom_range(99) < send_gap_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_req_type <= rq;
        i_coord_x <= cx;
        i_coord_y <= cy;
        i_coord_z <= cz;
        i_slot_index <= si;
        i_slot_key <= sk;
        i_slot_handle <= sh;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(predict_word(rq, cx, cy, cz, si, sk, sh));
        @(negedge i_clk);
    endtask

    task automatic lookup_region(logic [9:0] rx, logic [9:0] ry, logic [9:0] rz);
        logic [31:0] cx, cy, cz;
        // sign-extend so the upper bits vary as well
        cx = {{22{rx[9]}}, rx} << cht_pkg::REGION_SHIFT | $urandom_range(63);
        cy = {{22{ry[9]}}, ry} << cht_pkg::REGION_SHIFT | $urandom_range(63);
        cz = {{22{rz[9]}}, rz} << cht_pkg::REGION_SHIFT | $urandom_range(63);
        send_word(cht_pkg::REQ_LOOKUP, cx, cy, cz, '0, '0, '0);
    endtask

    // Drop start and hold off until every predicted word has come back
    task automatic drain_results();
        start <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        cht_pkg::t_res want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result word key=%h", o_key);
            end else begin
                want = pending_results.pop_front();
                if (o_found !== want.found || o_position !== want.position ||
                    o_handle !== want.handle || o_key !== want.key ||
                    o_done_res !== want.done_res) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch exp f=%b p=%0d h=%h k=%h d=%b got f=%b p=%0d h=%h k=%h d=%b",
                                 want.found, want.position, want.handle, want.key,
                                 want.done_res, o_found, o_position, o_handle, o_key,
                                 o_done_res);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > 64'd20000000) begin
            $display("chunk_hash_table_lookup test failed");
            $finish;
        end
    end

    task automatic test_directed();
        send_word(cht_pkg::REQ_LOOKUP, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                  '0, '0, '0);
        send_word(cht_pkg::REQ_LOOKUP, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                  '0, '0, '0);
        send_word(cht_pkg::REQ_WRITE, '0, '0, '0, 6'd0, 31'h4000_0000, 16'hFFFF);
        send_word(cht_pkg::REQ_WRITE, '0, '0, '0, 6'd63, 31'h7FFF_FFFF, 16'h0000);
        send_word(cht_pkg::REQ_WRITE, '0, '0, '0, 6'd5, 31'd1, 16'hA5A5);
        send_word(cht_pkg::REQ_WRITE, '0, '0, '0, 6'd9,
                  {1'b0, 10'd3, 10'd2, 10'd1} + 31'd1, 16'h1234);
        send_word(cht_pkg::REQ_LOOKUP, 32'd0, 32'd0, 32'd0, '0, '0, '0);
        send_word(cht_pkg::REQ_SORT, '0, '0, '0, '0, '0, '0);
        send_word(cht_pkg::REQ_LOOKUP, 32'd63, 32'd0, 32'd0, '0, '0, '0);
        send_word(cht_pkg::REQ_LOOKUP, 32'd0, 32'd0, 32'd0, '0, '0, '0);
        lookup_region(10'd1, 10'd2, 10'd3);
        lookup_region(10'd1, 10'd2, 10'd3);
        send_word(cht_pkg::REQ_WRITE, '0, '0, '0, 6'd20, 31'h5555_5555, 16'h0F0F);
        lookup_region(10'd1, 10'd2, 10'd3);
        send_word(cht_pkg::REQ_NONE, '1, '1, '1, '1, '1, '1);
        send_word(cht_pkg::REQ_SORT, '0, '0, '0, '0, '0, '0);
        lookup_region(10'd1, 10'd2, 10'd3);
        drain_results();
    endtask

    // Random mix of writes with keys from a small region pool, sorts, unused codes and lookups
    task automatic test_random(int n_items);
        logic [9:0] px [8], py [8], pz [8];
        int k, sel;
        for (int i = 0; i < 8; i++) begin
            px[i] = 10'($urandom);
            py[i] = 10'($urandom);
            pz[i] = 10'($urandom);
        end
        k = 0;
        while (k < n_items) begin
            sel = $urandom_range(99);
            if (sel < 25) begin
                int p;
                p = $urandom_range(7);
                send_word(cht_pkg::REQ_WRITE, $urandom, $urandom, $urandom,
                          cht_pkg::SLOT_W'($urandom),
                          ($urandom_range(3) == 0) ? 31'($urandom) :
                          {1'b0, pz[p], py[p], px[p]} + 31'd1,
                          cht_pkg::HANDLE_W'($urandom));
            end else if (sel < 27) begin
                send_word(cht_pkg::REQ_SORT, $urandom, $urandom, $urandom,
                          cht_pkg::SLOT_W'($urandom), cht_pkg::KEY_W'($urandom),
                          cht_pkg::HANDLE_W'($urandom));
            end else if (sel < 29) begin
                send_word(cht_pkg::REQ_NONE, $urandom, $urandom, $urandom,
                          cht_pkg::SLOT_W'($urandom), cht_pkg::KEY_W'($urandom),
                          cht_pkg::HANDLE_W'($urandom));
            end else if (sel < 85) begin
                sel = $urandom_range(7);
                lookup_region(px[sel], py[sel], pz[sel]);
            end else begin
                send_word(cht_pkg::REQ_LOOKUP, $urandom, $urandom, $urandom,
                          cht_pkg::SLOT_W'($urandom), cht_pkg::KEY_W'($urandom),
                          cht_pkg::HANDLE_W'($urandom));
            end
            if (k == n_items / 2) drain_results();
            k++;
        end
        drain_results();
    endtask

    initial begin
        for (int i = 0; i < cht_pkg::TABLE_DEPTH; i++) begin
            tbl_key[i] = '0;
            tbl_handle[i] = '0;
        end
        prev_region[0] = '0;
        prev_region[1] = '0;
        prev_region[2] = '0;
        hit_ok = 1'b0;
        hit_res = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        send_gap_pct = 12;
        test_random(580);
        send_gap_pct = 86;
        test_random(580);
        send_gap_pct = 0;
        test_random(580);
        repeat (50) @(negedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("chunk_hash_table_lookup test passed");
        else
            $display("chunk_hash_table_lookup test failed");
        $finish;
    end
endmodule
